[src/bnti_pkg.sv]
package bnti_pkg;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 5;
  localparam int CHARS_W    = 64;
  localparam int OUT_W      = 32;
  localparam int VALUE_W    = 32;
  localparam int MAX_DIGITS = 16;
  localparam int DIGIT_W    = (MAX_DIGITS > 2) ? $clog2(MAX_DIGITS) : 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [LEN_W-1:0]   RST_LENGTH     = 5'd10;
  localparam logic [CHARS_W-1:0] RST_CHARS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CHARS_W-1:0] RST_CHARS_HIGH = 64'h0000_0000_0000_3938;

  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic               acc_en;
    logic [DIGIT_W-1:0] digit;
    logic [LEN_W-1:0]   base;
    logic               last;
    logic               neg;
    logic               ok;
  } q_entry_t;

endpackage

[src/bnti_channels.sv]
interface bnti_text_if import bnti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              end_of_text;
  modport source(output valid, character, end_of_text, input ready);
  modport sink(input valid, character, end_of_text, output ready);
endinterface

interface bnti_result_if import bnti_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  logic                    alphabet_valid;
  modport source(output valid, value, alphabet_valid, input ready);
  modport sink(input valid, value, alphabet_valid, output ready);
endinterface

interface bnti_cfg_if import bnti_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CHARS_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[src/base_n_text_to_integer.sv]
// Text to signed integer converter with a configurable digit alphabet.
// text:   one character per word; end_of_text marks the final character.
// result: one word per string, issued after the final character: value
//         (signed, wraps modulo 2^32) and alphabet_valid. value is zero
//         when the alphabet is invalid.
// cfg:    register writes (0 length, 1 chars 0..7, 2 chars 8..15); always
//         ready. Write only while no string is in flight.
// Throughput: one character per cycle while the queue has room, set by the
// multiply-add on the accumulator in the back end.
// Result path: the final character is written into the queue, and the back
// end registers the result when it pops that word.
// A 4-word queue separates the parser from the accumulator, so text keeps
// flowing while a result waits; a stalled result holds its value and blocks
// the back end only at the next end-of-text word, after which text.ready
// drops once the queue fills.
// Reset: synchronous; restores alphabet "0123456789" (base 10), empties the
// queue and clears the parser and accumulator. No clearing pass is needed.
module base_n_text_to_integer import bnti_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  bnti_text_if.sink     text,
  bnti_cfg_if.sink      cfg,
  bnti_result_if.source result
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_entry, pop_entry;

  bnti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  bnti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_entry  (push_entry),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_entry (pop_entry)
  );

  bnti_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_entry (pop_entry),
    .result  (result)
  );

endmodule

[src/bnti_front.sv]
module bnti_front import bnti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bnti_text_if.sink text,
  bnti_cfg_if.sink  cfg,
  output logic      push_valid,
  input  logic      push_ready,
  output q_entry_t  push_entry
);

  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [LEN_W-1:0]     alphabet_length;
  logic [CHARS_W-1:0]   alphabet_chars_low;
  logic [CHARS_W-1:0]   alphabet_chars_high;
  logic [2*CHARS_W-1:0] chars;
  logic [LEN_W-1:0]     used_len;

  logic [1:0]         phase, phase_next;
  logic               neg, neg_next;
  logic               hit, ok, is_sp, acc_en, accept;
  logic [DIGIT_W-1:0] digit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_length     <= RST_LENGTH;
      alphabet_chars_low  <= RST_CHARS_LOW;
      alphabet_chars_high <= RST_CHARS_HIGH;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LENGTH:     alphabet_length     <= cfg.data[LEN_W-1:0];
        REG_CHARS_LOW:  alphabet_chars_low  <= cfg.data;
        REG_CHARS_HIGH: alphabet_chars_high <= cfg.data;
        default: ;
      endcase
    end
  end

  assign chars    = {alphabet_chars_high, alphabet_chars_low};
  assign used_len = (alphabet_length > LEN_W'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS)
                                                            : alphabet_length;

  // digit lookup, lowest index wins
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
      if (LEN_W'(i) < used_len && chars[8*i +: CHAR_W] == text.character) begin
        hit   = 1'b1;
        digit = DIGIT_W'(i);
      end
    end
  end

  // alphabet check
  always_comb begin
    logic [CHAR_W-1:0] ci;
    ok = (alphabet_length >= LEN_W'(2)) && (alphabet_length <= LEN_W'(MAX_DIGITS));
    for (int i = 0; i < MAX_DIGITS; i++) begin
      ci = chars[8*i +: CHAR_W];
      if (LEN_W'(i) < alphabet_length) begin
        if (ci == CH_PLUS || ci == CH_MINUS || ci == CH_NUL || ci == CH_SPACE ||
            (ci >= CH_TAB && ci <= CH_CR))
          ok = 1'b0;
        for (int j = i + 1; j < MAX_DIGITS; j++) begin
          if (LEN_W'(j) < alphabet_length && chars[8*j +: CHAR_W] == ci)
            ok = 1'b0;
        end
      end
    end
  end

  assign is_sp = (text.character >= CH_TAB && text.character <= CH_CR) ||
                 text.character == CH_SPACE;

  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    acc_en     = 1'b0;
    if (phase_next == PH_SPACE && !is_sp)
      phase_next = PH_SIGN;
    if (phase_next == PH_SIGN) begin
      if (text.character == CH_MINUS)
        neg_next = !neg;
      else if (text.character != CH_PLUS)
        phase_next = PH_DIGIT;
    end
    if (phase_next == PH_DIGIT) begin
      if (hit)
        acc_en = 1'b1;
      else
        phase_next = PH_DONE;
    end
  end

  assign text.ready = push_ready;
  assign accept     = text.valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      neg   <= 1'b0;
    end else if (accept) begin
      if (text.end_of_text) begin
        phase <= PH_SPACE;
        neg   <= 1'b0;
      end else begin
        phase <= phase_next;
        neg   <= neg_next;
      end
    end
  end

  assign push_valid        = text.valid;
  assign push_entry.acc_en = acc_en;
  assign push_entry.digit  = digit;
  assign push_entry.base   = used_len;
  assign push_entry.last   = text.end_of_text;
  assign push_entry.neg    = neg_next;
  assign push_entry.ok     = ok;

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && text.end_of_text |=> phase == PH_SPACE && !neg)
    else $error("parser not restarted after end of text");

endmodule

[src/bnti_queue.sv]
module bnti_queue import bnti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  q_entry_t in_entry,
  output logic     out_valid,
  input  logic     out_ready,
  output q_entry_t out_entry
);

  q_entry_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_entry = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= in_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)
        rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)
        count <= count + QCNT_W'(1);
      else if (pop && !push)
        count <= count - QCNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    QPTR_W'(rd_ptr + QPTR_W'(count)) == wr_ptr)
    else $error("queue pointers disagree with count");

endmodule

[src/bnti_back.sv]
module bnti_back import bnti_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  q_entry_t      q_entry,
  bnti_result_if.source result
);

  logic [VALUE_W-1:0]        acc, acc_new, signed_acc;
  logic                      out_valid, pop;
  logic signed [OUT_W-1:0]   out_value;
  logic                      out_ok;

  assign q_ready = !q_entry.last || !out_valid || result.ready;
  assign pop     = q_valid && q_ready;

  assign acc_new = q_entry.acc_en
      ? VALUE_W'(acc * VALUE_W'(q_entry.base) + VALUE_W'(q_entry.digit))
      : acc;
  assign signed_acc = q_entry.neg ? VALUE_W'(-acc_new) : acc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && q_entry.last)
        out_valid <= 1'b1;
      else if (result.ready)
        out_valid <= 1'b0;
      if (pop) begin
        if (q_entry.last)
          acc <= '0;
        else
          acc <= acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      out_value <= q_entry.ok ? OUT_W'($signed(signed_acc)) : '0;
      out_ok    <= q_entry.ok;
    end
  end

  assign result.valid          = out_valid;
  assign result.value          = out_value;
  assign result.alphabet_valid = out_ok;

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    pop && q_entry.last |=> out_valid && acc == '0)
    else $error("last word did not produce a result");

  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_value == '0)
    else $error("non-zero value with invalid alphabet");

endmodule

[bench/tb_base_n_text_to_integer.sv]
`timescale 1ns / 100ps

module tb_base_n_text_to_integer;
  import bnti_pkg::*;

  localparam int ITEMS_TOTAL = 450;
  localparam int CALM_AFTER  = 390;
  localparam int LONG_HOLD   = 120;
  localparam int SETTLE      = 8;

  typedef logic [CHAR_W-1:0] char_t;
  typedef enum logic [1:0] {SKIP_SPACE, READ_SIGN, READ_DIGITS, PARSE_DONE} parse_phase_t;
  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    alphabet_valid;
  } conversion_t;

  function automatic bit is_blank(char_t c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic bit is_reserved(char_t c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_NUL || is_blank(c);
  endfunction

  class text_int_scoreboard;
    logic [LEN_W-1:0]   alpha_len;
    logic [CHARS_W-1:0] chars_lo;
    logic [CHARS_W-1:0] chars_hi;
    parse_phase_t       phase;
    bit                 negate;
    logic [VALUE_W-1:0] acc;
    conversion_t        awaited_values[$];
    int                 failures;

    function new();
      alpha_len = RST_LENGTH;
      chars_lo  = RST_CHARS_LOW;
      chars_hi  = RST_CHARS_HIGH;
      failures  = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase  = SKIP_SPACE;
      negate = 1'b0;
      acc    = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CHARS_W-1:0] data);
      case (index)
        REG_LENGTH:     alpha_len = data[LEN_W-1:0];
        REG_CHARS_LOW:  chars_lo  = data;
        REG_CHARS_HIGH: chars_hi  = data;
        default: ;
      endcase
    endfunction

    function int used_len();
      return (alpha_len > MAX_DIGITS) ? MAX_DIGITS : int'(alpha_len);
    endfunction

    function char_t digit_char(int i);
      logic [2*CHARS_W-1:0] both;
      both = {chars_hi, chars_lo};
      return both[CHAR_W*i +: CHAR_W];
    endfunction

    function bit alphabet_ok();
      int n;
      char_t c;
      n = alpha_len;
      if (n < 2 || n > MAX_DIGITS) return 1'b0;
      for (int i = 0; i < n; i++) begin
        c = digit_char(i);
        if (is_reserved(c)) return 1'b0;
        for (int j = i + 1; j < n; j++)
          if (digit_char(j) == c) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int digit_index(char_t c);
      for (int i = 0; i < used_len(); i++)
        if (digit_char(i) == c) return i;
      return -1;
    endfunction

    // one accepted text word; queues the conversion on end of text
    function void note_char(char_t c, logic last);
      int d;
      conversion_t r;
      logic [VALUE_W-1:0] mag;
      if (phase == SKIP_SPACE && !is_blank(c)) phase = READ_SIGN;
      if (phase == READ_SIGN) begin
        if (c == CH_MINUS) negate = !negate;
        else if (c != CH_PLUS) phase = READ_DIGITS;
      end
      if (phase == READ_DIGITS) begin
        d = digit_index(c);
        if (d < 0) phase = PARSE_DONE;
        else acc = acc * VALUE_W'(used_len()) + VALUE_W'(d);
      end
      if (last) begin
        mag = negate ? -acc : acc;
        r.alphabet_valid = alphabet_ok();
        if (r.alphabet_valid) r.value = $signed(mag);
        else r.value = '0;
        awaited_values.push_back(r);
        clear_parse();
      end
    endfunction

    function void check_result(logic signed [OUT_W-1:0] value, logic ok);
      conversion_t want;
      if (awaited_values.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result word: value %0d alphabet_valid %0b",
                   $realtime, value, ok);
        return;
      end
      want = awaited_values.pop_front();
      if (value !== want.value || ok !== want.alphabet_valid) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result wrong: expected value %0d valid %0b, got value %0d valid %0b",
                   $realtime, want.value, want.alphabet_valid, value, ok);
      end
    endfunction

    function int pending();
      return awaited_values.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bnti_text_if   text_ch();
  bnti_cfg_if    cfg_ch();
  bnti_result_if res_ch();

  base_n_text_to_integer DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  text_int_scoreboard sb;
  int items_sent   = 0;
  int results_seen = 0;
  int text_gap_pct = 25;
  bit calm         = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("base_n_text_to_integer: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      sb.check_result(res_ch.value, res_ch.alphabet_valid);
      results_seen++;
    end
  end

  // result side: random stall bursts, two long holds to back the block up
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int holds_done;
    int stall_pct;
    int mode_left;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    stall_pct  = 20;
    mode_left  = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (calm) begin
        res_ch.ready <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 8 : 60)) begin
        hold_left = LONG_HOLD - 1;
        holds_done++;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 15);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 80);
        stall_pct = $urandom_range(0, 1) ? 0 : 20;
      end else begin
        mode_left--;
      end
    end
  end

  task automatic send_text(input char_t chars[$]);
    for (int i = 0; i < chars.size(); i++) begin
      if (!calm && $urandom_range(0, 99) < text_gap_pct) begin
        @(negedge clk);
        text_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      @(negedge clk);
      text_ch.valid       <= 1'b1;
      text_ch.character   <= chars[i];
      text_ch.end_of_text <= (i == chars.size() - 1);
      do @(posedge clk); while (text_ch.ready !== 1'b1);
      sb.note_char(chars[i], i == chars.size() - 1);
      items_sent++;
      if (items_sent >= CALM_AFTER) calm = 1'b1;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CHARS_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // n distinct legal digit characters in the low slots, junk above
  function automatic logic [2*CHARS_W-1:0] random_alphabet(int n);
    logic [2*CHARS_W-1:0] both;
    char_t c;
    bit clash;
    both = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      do begin
        c = char_t'($urandom_range(0, 255));
        clash = is_reserved(c);
        for (int j = 0; j < i; j++)
          if (both[CHAR_W*j +: CHAR_W] == c) clash = 1'b1;
      end while (clash);
      both[CHAR_W*i +: CHAR_W] = c;
    end
    return both;
  endfunction

  function automatic char_t random_blank();
    return ($urandom_range(0, 5) == 5) ? CH_SPACE : char_t'(CH_TAB + $urandom_range(0, 4));
  endfunction

  // mostly well-formed numbers in the current alphabet, some noise
  function automatic void make_text(output char_t chars[$]);
    int kind;
    int n;
    chars = {};
    n = sb.used_len();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 8)) chars.push_back(char_t'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) chars.push_back(random_blank());
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4))
          chars.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      if (kind >= 25)
        repeat ($urandom_range(1, kind >= 90 ? 14 : 7))
          chars.push_back(n > 0 ? sb.digit_char($urandom_range(0, n - 1))
                                : char_t'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 2)) chars.push_back(char_t'($urandom_range(0, 255)));
      if (chars.size() == 0) chars.push_back(char_t'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    char_t chars[$];
    string digits_s;
    int phase_no;
    int phase_end;
    int len;
    int a;
    int b;
    char_t bad;
    logic [2*CHARS_W-1:0] pair;

    sb = new();
    text_ch.valid       = 1'b0;
    text_ch.character   = '0;
    text_ch.end_of_text = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_LENGTH;
    cfg_ch.data         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset alphabet: blanks, sign run, digits cut by a NUL, lone oddities, wrap
    chars = '{CH_TAB, 8'h0A, CH_SPACE, CH_MINUS, CH_PLUS, CH_MINUS, CH_MINUS,
              "5", "0", CH_NUL, "7"};
    send_text(chars);
    chars = '{8'hFF};
    send_text(chars);
    digits_s = "2147483648";
    chars = {};
    for (int i = 0; i < digits_s.len(); i++) chars.push_back(digits_s[i]);
    send_text(chars);
    chars = '{CH_MINUS};
    send_text(chars);
    chars = '{CH_CR};
    send_text(chars);
    drain();

    phase_no = 0;
    while (items_sent < ITEMS_TOTAL) begin
      case (phase_no)
        0: begin
          len  = 16;
          pair = {64'h6665_6463_6261_3938, 64'h3736_3534_3332_3130};
        end
        1: begin
          len  = 2;
          pair = random_alphabet(2);
        end
        2: begin
          len  = 0;
          pair = {$urandom, $urandom, $urandom, $urandom};
        end
        3: begin
          len  = 1;
          pair = random_alphabet(16);
        end
        4: begin
          len  = 16;
          pair = '1;
        end
        5: begin
          len  = $urandom_range(2, 16);
          pair = '0;
        end
        6: begin
          len = $urandom_range(2, 16);
          pair = random_alphabet(len);
          case ($urandom_range(0, 3))
            0: bad = CH_PLUS;
            1: bad = CH_MINUS;
            2: bad = CH_NUL;
            default: bad = random_blank();
          endcase
          pair[CHAR_W*$urandom_range(0, len - 1) +: CHAR_W] = bad;
        end
        7: begin
          len  = $urandom_range(2, 16);
          pair = random_alphabet(len);
          a = $urandom_range(0, len - 2);
          b = $urandom_range(a + 1, len - 1);
          pair[CHAR_W*b +: CHAR_W] = pair[CHAR_W*a +: CHAR_W];
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            len  = $urandom_range(0, 16);
            pair = {$urandom, $urandom, $urandom, $urandom};
          end else begin
            len  = $urandom_range(2, 16);
            pair = random_alphabet(len);
          end
        end
      endcase
      write_reg(REG_LENGTH, CHARS_W'(len));
      write_reg(REG_CHARS_LOW, pair[CHARS_W-1:0]);
      write_reg(REG_CHARS_HIGH, pair[2*CHARS_W-1:CHARS_W]);
      text_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      phase_end = items_sent + 30;
      while (items_sent < phase_end && items_sent < ITEMS_TOTAL) begin
        make_text(chars);
        send_text(chars);
      end
      drain();
      phase_no++;
    end

    if (sb.failures == 0 && sb.pending() == 0)
      $display("base_n_text_to_integer: match");
    else
      $display("base_n_text_to_integer: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/bnti_pkg.sv
src/bnti_channels.sv
src/bnti_front.sv
src/bnti_queue.sv
src/bnti_back.sv
src/base_n_text_to_integer.sv
bench/tb_base_n_text_to_integer.sv
